// ----- rtl/record_quicksort_by_key_defines.svh -----
// Assertion macros for the checker in rqs_checker.sv
`ifndef RECORD_QUICKSORT_BY_KEY_DEFINES_SVH
`define RECORD_QUICKSORT_BY_KEY_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define RQS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset
`define RQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define RQS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/rqs_pkg.sv -----
`default_nettype none
package rqs_pkg;
  localparam int RECORDS  = 64;
  localparam int KEY_BITS = 16;
  localparam int TAG_BITS = 10;
  localparam int IDX_W    = $clog2(RECORDS);
  localparam int CNT_W    = $clog2(RECORDS + 1);
  localparam int REC_W    = KEY_BITS + TAG_BITS;
  localparam int RNG_W    = 2 * IDX_W;
  localparam int DATA_W   = ((REC_W + 7) / 8) * 8;
endpackage
`default_nettype wire

// ----- rtl/rqs_ram.sv -----
`default_nettype none
module rqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/record_quicksort_by_key.sv -----
// Channel  | Dir | tdata (low bit up)           | tlast    | tuser
// s_axis   | in  | key[15:0], tag[25:16], 0 pad  | last     | -
// m_axis   | out | key_out[15:0], tag_out[25:16] | last_out | overflow
// Loading accepts one word per cycle; a word is taken only while no set is
// being sorted or emitted. Sorting runs in place in one record RAM with a
// registered read, so each compare takes a read state and a wait state and
// each swap two writes. A set of N random keys needs about 2*N*ln(N)
// compares; presorted keys approach N*N. Each word is emitted through the
// read, wait and hold states, and the next is read only after it is taken.
// Reset is synchronous; the RAMs need no clearing.
`default_nettype none
module record_quicksort_by_key
  import rqs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,   // key, tag, zero pad
  input  wire logic              s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [DATA_W-1:0] m_axis_tdata,   // key_out, tag_out, zero pad
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser    // overflow
);
  typedef enum logic [4:0] {
    S_LOAD, S_POP, S_POP_WAIT, S_INNER, S_PIV_WAIT, S_UP, S_UP_WAIT,
    S_DN, S_DN_WAIT, S_SWAP_A, S_SWAP_B, S_FIN_A, S_FIN_B, S_PUSH,
    S_EMIT_RD, S_EMIT_WAIT, S_EMIT_HOLD
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count, up, dn, sp;
  logic [IDX_W-1:0]   lo, hi, idx;
  logic               dropped;
  logic [REC_W-1:0]   pivot_rec, rec_up, rec_dn;
  logic [REC_W-1:0]   out_rec;
  logic               out_last, out_ovf, out_valid;

  logic               rec_we;
  logic [IDX_W-1:0]   rec_waddr, rec_raddr;
  logic [REC_W-1:0]   rec_wdata, rec_rdata;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_waddr, stk_raddr;
  logic [RNG_W-1:0]   stk_wdata, stk_rdata;

  logic               s_fire, full, push_ok;
  logic [CNT_W-1:0]   cnt_new, up_inc, dn_dec, dn_inc, sp_dec, cnt_m1;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign full    = (count == CNT_W'(RECORDS));
  assign cnt_new = full ? count : count + CNT_W'(1);
  assign cnt_m1  = cnt_new - CNT_W'(1);
  assign up_inc  = up + CNT_W'(1);
  assign dn_dec  = dn - CNT_W'(1);
  assign dn_inc  = dn + CNT_W'(1);
  assign sp_dec  = sp - CNT_W'(1);
  assign push_ok = (dn_inc < CNT_W'(hi)) && (sp < CNT_W'(RECORDS));

  rqs_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  rqs_ram #(.WIDTH(RNG_W), .DEPTH(RECORDS)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Steer RAM ports by state
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = count[IDX_W-1:0];
    rec_wdata = s_axis_tdata[REC_W-1:0];
    rec_raddr = lo;
    stk_we    = 1'b0;
    stk_waddr = sp[IDX_W-1:0];
    stk_wdata = {dn_inc[IDX_W-1:0], hi};
    stk_raddr = sp_dec[IDX_W-1:0];
    case (state)
      S_LOAD:    rec_we = s_fire && !full;
      S_UP:      rec_raddr = up_inc[IDX_W-1:0];
      S_DN:      rec_raddr = dn_dec[IDX_W-1:0];
      S_SWAP_A: begin
        rec_we = 1'b1; rec_waddr = up[IDX_W-1:0]; rec_wdata = rec_dn;
      end
      S_SWAP_B: begin
        rec_we = 1'b1; rec_waddr = dn[IDX_W-1:0]; rec_wdata = rec_up;
      end
      S_FIN_A: begin
        rec_we = 1'b1; rec_waddr = lo; rec_wdata = rec_dn;
      end
      S_FIN_B: begin
        rec_we = 1'b1; rec_waddr = dn[IDX_W-1:0]; rec_wdata = pivot_rec;
      end
      S_PUSH:    stk_we = push_ok;
      S_EMIT_RD: rec_raddr = idx;
      default: ;
    endcase
  end

  // Sequence load, partition, stack and emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
      sp        <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (s_fire) begin
            count   <= cnt_new;
            dropped <= dropped | full;
            if (s_axis_tlast) begin
              if (cnt_new > CNT_W'(1)) begin
                lo    <= '0;
                hi    <= cnt_m1[IDX_W-1:0];
                sp    <= '0;
                state <= S_INNER;
              end else begin
                idx   <= '0;
                state <= S_EMIT_RD;
              end
            end
          end
        end
        S_POP: begin
          if (sp == '0) begin
            idx   <= count[IDX_W-1:0] - IDX_W'(1);
            state <= S_EMIT_RD;
          end else begin
            sp    <= sp_dec;
            state <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          lo    <= stk_rdata[RNG_W-1:IDX_W];
          hi    <= stk_rdata[IDX_W-1:0];
          state <= S_INNER;
        end
        S_INNER: state <= (lo < hi) ? S_PIV_WAIT : S_POP;
        S_PIV_WAIT: begin
          pivot_rec <= rec_rdata;
          up        <= CNT_W'(lo);
          dn        <= CNT_W'(hi) + CNT_W'(1);
          state     <= S_UP;
        end
        S_UP: begin
          up    <= up_inc;
          state <= (up_inc <= CNT_W'(hi)) ? S_UP_WAIT : S_DN;
        end
        S_UP_WAIT: begin
          if (rec_rdata[KEY_BITS-1:0] < pivot_rec[KEY_BITS-1:0]) begin
            state <= S_UP;
          end else begin
            rec_up <= rec_rdata;
            state  <= S_DN;
          end
        end
        S_DN: begin
          dn    <= dn_dec;
          state <= S_DN_WAIT;
        end
        S_DN_WAIT: begin
          if (rec_rdata[KEY_BITS-1:0] > pivot_rec[KEY_BITS-1:0]) begin
            state <= S_DN;
          end else begin
            rec_dn <= rec_rdata;
            state  <= (up < dn) ? S_SWAP_A : S_FIN_A;
          end
        end
        S_SWAP_A: state <= S_SWAP_B;
        S_SWAP_B: state <= S_UP;
        S_FIN_A:  state <= S_FIN_B;
        S_FIN_B:  state <= S_PUSH;
        S_PUSH: begin
          if (push_ok) begin
            sp <= sp + CNT_W'(1);
          end
          hi    <= (dn > CNT_W'(lo)) ? dn_dec[IDX_W-1:0] : lo;
          state <= S_INNER;
        end
        S_EMIT_RD: state <= S_EMIT_WAIT;
        S_EMIT_WAIT: begin
          out_rec   <= rec_rdata;
          out_last  <= (idx == '0);
          out_ovf   <= dropped;
          out_valid <= 1'b1;
          state     <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            if (idx == '0) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              idx   <= idx - IDX_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign s_axis_tready = (state == S_LOAD);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'(out_rec);
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_ovf;
endmodule
`default_nettype wire

// ----- rtl/rqs_checker.sv -----
`default_nettype none
`include "record_quicksort_by_key_defines.svh"
module rqs_checker
  import rqs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [DATA_W-1:0] m_axis_tdata,
  input wire logic              m_axis_tlast,
  input wire logic              m_axis_tuser
);
  // Loading and emitting never overlap
  `RQS_ASSERT_IMP(a_excl, m_axis_tvalid, !s_axis_tready)
  // A stalled word stays offered and unchanged
  `RQS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
  // After the final word the block returns to loading
  `RQS_ASSERT_NEXT(a_end, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid && s_axis_tready)
  // Reset drops any pending word
  `RQS_ASSERT_RST(a_rst, rst, !m_axis_tvalid)
endmodule

bind record_quicksort_by_key rqs_checker u_rqs_checker (.*);
`default_nettype wire

// ----- tb/record_quicksort_by_key_tb.sv -----
`default_nettype none
module record_quicksort_by_key_tb;
  import rqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic                last;
    logic                overflow;
  } ranked_rec_t;

  // Sorting scoreboard: mirrors the set, sorts on the last word
  class sort_scoreboard;
    logic [KEY_BITS-1:0] keys[RECORDS];
    logic [TAG_BITS-1:0] tags[RECORDS];
    int held;
    bit dropped;
    ranked_rec_t ranked_q[$];
    int errors;
    int results_seen;
    int sets_done;

    function void swap_recs(int a, int b);
      logic [KEY_BITS-1:0] k;
      logic [TAG_BITS-1:0] t;
      k = keys[a]; t = tags[a];
      keys[a] = keys[b]; tags[a] = tags[b];
      keys[b] = k; tags[b] = t;
    endfunction

    function int partition_range(int lo, int hi);
      logic [KEY_BITS-1:0] pivot;
      int up;
      int down;
      pivot = keys[lo];
      up = lo;
      down = hi + 1;
      do begin
        do up++; while (up <= hi && keys[up] < pivot);
        do down--; while (down >= lo && keys[down] > pivot);
        if (up < down) swap_recs(up, down);
      end while (up < down);
      swap_recs(lo, down);
      return down;
    endfunction

    function void quicksort_set();
      int stk_lo[RECORDS];
      int stk_hi[RECORDS];
      int sp;
      int lo;
      int hi;
      int q;
      sp = 0;
      if (held > 1) begin
        stk_lo[0] = 0; stk_hi[0] = held - 1; sp = 1;
      end
      while (sp > 0) begin
        sp--;
        lo = stk_lo[sp];
        hi = stk_hi[sp];
        while (lo < hi) begin
          q = partition_range(lo, hi);
          if (q + 1 < hi && sp < RECORDS) begin
            stk_lo[sp] = q + 1; stk_hi[sp] = hi; sp++;
          end
          hi = q - 1;
        end
      end
    endfunction

    // Note one accepted input word
    function void note_record(logic [KEY_BITS-1:0] k, logic [TAG_BITS-1:0] t, logic l);
      ranked_rec_t r;
      if (held < RECORDS) begin
        keys[held] = k; tags[held] = t; held++;
      end else begin
        dropped = 1;
      end
      if (!l) return;
      quicksort_set();
      for (int i = held - 1; i >= 0; i--) begin
        r.key = keys[i];
        r.tag = tags[i];
        r.last = (i == 0);
        r.overflow = dropped;
        ranked_q.push_back(r);
      end
      held = 0;
      dropped = 0;
      sets_done++;
    endfunction

    // Check one output word against the oldest expectation
    function void check_ranked(ranked_rec_t got);
      ranked_rec_t want;
      results_seen++;
      if (ranked_q.size() == 0) begin
        $display("%0t: unexpected word key=%h tag=%h last=%b ovf=%b",
                 $time, got.key, got.tag, got.last, got.overflow);
        errors++;
        return;
      end
      want = ranked_q.pop_front();
      if (got.key !== want.key) begin
        $display("%0t: key mismatch expected %h actual %h", $time, want.key, got.key);
        errors++;
      end
      if (got.tag !== want.tag) begin
        $display("%0t: tag mismatch expected %h actual %h", $time, want.tag, got.tag);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow mismatch expected %b actual %b",
                 $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  sort_scoreboard sb = new();
  bit calm = 0;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 1500000;

  record_quicksort_by_key dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, check each accepted word
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_ranked('{key: m_axis_tdata[KEY_BITS-1:0],
                        tag: m_axis_tdata[REC_W-1:KEY_BITS],
                        last: m_axis_tlast, overflow: m_axis_tuser});
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
  end

  // Send one word, with a random idle gap first; valid stays up afterwards
  task automatic send_word(logic [KEY_BITS-1:0] k, logic [TAG_BITS-1:0] t, logic l);
    while (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= DATA_W'({t, k});
    s_axis_tlast <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_record(k, t, l);
  endtask

  // Drop valid, then hold until every expected word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (sb.ranked_q.size() != 0) @(posedge clk);
  endtask

  // Random set of n records; keys from a narrow range when narrow is set, to force ties
  task automatic send_set(int n, bit narrow);
    for (int i = 0; i < n; i++)
      send_word(narrow ? KEY_BITS'($urandom_range(3)) : KEY_BITS'($urandom),
                TAG_BITS'($urandom), i == n - 1);
  endtask

  initial begin
    int sent;
    int n;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: single record, extremes, ties
    send_word('1, '1, 1'b1);
    send_word('0, '0, 1'b0);
    send_word('1, '1, 1'b0);
    send_word(16'h8000, 10'h200, 1'b0);
    send_word(16'h8000, 10'h155, 1'b0);
    send_word(16'h0001, 10'h2AA, 1'b1);
    send_word(16'd5, 10'd1, 1'b0);
    send_word(16'd5, 10'd2, 1'b0);
    send_word(16'd5, 10'd3, 1'b1);
    wait_drained();
    // Full set, then overflow with the last two words dropped
    send_set(RECORDS, 0);
    for (int i = 0; i < RECORDS + 2; i++)
      send_word(KEY_BITS'($urandom), TAG_BITS'($urandom), i == RECORDS + 1);
    wait_drained();
    sent = 9 + 2 * RECORDS + 2;
    // Random sets, mostly small; a calm stretch in the middle
    while (sent < 410) begin
      calm = (sent > 250 && sent < 320);
      n = ($urandom_range(9) == 0) ? $urandom_range(RECORDS + 3, 30)
                                   : $urandom_range(12, 1);
      send_set(n, $urandom_range(2) == 0);
      sent += n;
      if ($urandom_range(4) == 0) wait_drained();
    end
    calm = 0;
    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d sets (%0d ranked words): single, tied, full and overflowing sets.",
             sb.sets_done, sb.results_seen);
    if (sb.errors == 0 && sb.ranked_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- record_quicksort_by_key.f -----
+incdir+rtl
rtl/rqs_pkg.sv
rtl/rqs_ram.sv
rtl/record_quicksort_by_key.sv
rtl/rqs_checker.sv
tb/record_quicksort_by_key_tb.sv
